@@ src/cidrmp_pkg.sv @@
`timescale 1ns / 1ps

package cidrmp_pkg;

  // fixed field widths of the stream payload
  localparam int CID_W  = 16;
  localparam int CODE_W = 21;

  // defaults for the table geometry
  localparam int DEF_CID_BITS  = 16;
  localparam int DEF_CODE_BITS = 21;

  // request kinds carried in the input tuser
  typedef enum logic [1:0] {
    REQ_TEXT  = 2'd0,
    REQ_WRITE = 2'd1,
    REQ_CLEAR = 2'd2
  } req_t;

  // decoder view of the current text byte
  typedef struct packed {
    logic             cid_vld;
    logic [CID_W-1:0] cid;
  } dec_res_t;

  // request from the control fsm to the byte emitter
  typedef struct packed {
    logic              load;
    logic              end_only;
    logic              last;
    logic [CODE_W-1:0] code;
  } emit_req_t;

endpackage

@@ src/cidrmp_table.sv @@
`timescale 1ns / 1ps

module cidrmp_table import cidrmp_pkg::*; #(
  parameter int CID_BITS  = DEF_CID_BITS,
  parameter int CODE_BITS = DEF_CODE_BITS
) (
  input  logic                 clk,
  input  logic                 we,
  input  logic [CID_BITS-1:0]  waddr,
  input  logic [CODE_BITS:0]   wdata,
  input  logic [CID_BITS-1:0]  raddr,
  output logic [CODE_BITS:0]   rdata
);

  localparam int DEPTH = 2 ** CID_BITS;

  // each word is {mark, code}
  logic [CODE_BITS:0] mem [DEPTH];
  logic [CODE_BITS:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    rdata_r <= mem[raddr];
  end

  assign rdata = rdata_r;

endmodule

@@ src/cidrmp_decode.sv @@
`timescale 1ns / 1ps

module cidrmp_decode import cidrmp_pkg::*; (
  input  logic     clk,
  input  logic     rst_n,
  input  logic     step,
  input  logic [7:0] text_byte,
  input  logic     text_last,
  output dec_res_t res
);

  logic [1:0]  rem_r, rem_nxt;
  logic [15:0] part_r, part_nxt;
  logic [7:0]  held_r, held_nxt;
  logic        hv_r, hv_nxt;
  logic        have_raw;
  logic [7:0]  raw;

  function automatic logic [7:0] to_raw(input logic [15:0] cp);
    return (cp[15:8] == 8'd0) ? cp[7:0] : 8'd0;
  endfunction

  always_comb begin
    rem_nxt  = rem_r;
    part_nxt = part_r;
    held_nxt = held_r;
    hv_nxt   = hv_r;
    have_raw = 1'b0;
    raw      = 8'd0;

    if (rem_r == 2'd1 || rem_r == 2'd2) begin
      // continuation byte, taken unchecked
      if (rem_r == 2'd2) begin
        part_nxt = part_r | {4'd0, text_byte[5:0], 6'd0};
      end else begin
        part_nxt = part_r | {10'd0, text_byte[5:0]};
      end
      rem_nxt = rem_r - 2'd1;
      if (rem_r == 2'd1) begin
        have_raw = 1'b1;
        raw      = to_raw(part_nxt);
      end
    end else begin
      rem_nxt = 2'd0;
      priority if (!text_byte[7]) begin
        have_raw = 1'b1;
        raw      = text_byte;
      end else if (text_byte[7:5] == 3'b110) begin
        part_nxt = {5'd0, text_byte[4:0], 6'd0};
        rem_nxt  = 2'd1;
      end else if (text_byte[7:4] == 4'b1110) begin
        part_nxt = {text_byte[3:0], 12'd0};
        rem_nxt  = 2'd2;
      end else begin
        have_raw = 1'b1;
        raw      = text_byte;
      end
    end

    // truncated sequence at end of text: missing bits are zero
    if (text_last && rem_nxt != 2'd0) begin
      have_raw = 1'b1;
      raw      = to_raw(part_nxt);
      rem_nxt  = 2'd0;
    end

    if (have_raw) begin
      if (hv_r) begin
        hv_nxt = 1'b0;
      end else begin
        held_nxt = raw;
        hv_nxt   = 1'b1;
      end
    end

    if (text_last) begin
      rem_nxt  = 2'd0;
      part_nxt = 16'd0;
      held_nxt = 8'd0;
      hv_nxt   = 1'b0;
    end
  end

  assign res.cid_vld = have_raw && hv_r;
  assign res.cid     = {held_r, raw};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      rem_r  <= 2'd0;
      part_r <= 16'd0;
      held_r <= 8'd0;
      hv_r   <= 1'b0;
    end else if (step) begin
      rem_r  <= rem_nxt;
      part_r <= part_nxt;
      held_r <= held_nxt;
      hv_r   <= hv_nxt;
    end
  end

endmodule

@@ src/cidrmp_emit.sv @@
`timescale 1ns / 1ps

module cidrmp_emit import cidrmp_pkg::*; (
  input  logic      clk,
  input  logic      rst_n,
  input  emit_req_t req,
  output logic      busy,
  output logic      out_tvalid,
  input  logic      out_tready,
  output logic [7:0] out_tdata,
  output logic [1:0] out_tuser,
  output logic      out_tlast
);

  logic [7:0] enc_b [4];
  logic [1:0] enc_lastix;
  logic [CODE_W-1:0] u;

  logic [7:0] byte_r [4];
  logic [1:0] idx_r;
  logic [1:0] lastix_r;
  logic       bval_r;
  logic       tend_r;
  logic       pending_r;

  logic       otv_r;
  logic [7:0] obyte_r;
  logic       obval_r;
  logic       orun_r;
  logic       oend_r;

  logic       push;
  logic       run_end;

  // utf-8 encoder
  always_comb begin
    u = req.code;
    enc_b[0] = 8'd0;
    enc_b[1] = 8'd0;
    enc_b[2] = 8'd0;
    enc_b[3] = 8'd0;
    priority if (u < CODE_W'(32'h80)) begin
      enc_b[0]   = u[7:0];
      enc_lastix = 2'd0;
    end else if (u < CODE_W'(32'h800)) begin
      enc_b[0]   = {3'b110, u[10:6]};
      enc_b[1]   = {2'b10, u[5:0]};
      enc_lastix = 2'd1;
    end else if (u < CODE_W'(32'h10000)) begin
      enc_b[0]   = {4'b1110, u[15:12]};
      enc_b[1]   = {2'b10, u[11:6]};
      enc_b[2]   = {2'b10, u[5:0]};
      enc_lastix = 2'd2;
    end else begin
      enc_b[0]   = {5'b11110, u[20:18]};
      enc_b[1]   = {2'b10, u[17:12]};
      enc_b[2]   = {2'b10, u[11:6]};
      enc_b[3]   = {2'b10, u[5:0]};
      enc_lastix = 2'd3;
    end
  end

  assign push    = pending_r && (!otv_r || out_tready);
  assign run_end = (idx_r == lastix_r);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pending_r <= 1'b0;
      otv_r     <= 1'b0;
    end else begin
      if (req.load) begin
        pending_r <= 1'b1;
        idx_r     <= 2'd0;
        bval_r    <= !req.end_only;
        tend_r    <= req.last;
        lastix_r  <= req.end_only ? 2'd0 : enc_lastix;
        for (int i = 0; i < 4; i++) begin
          byte_r[i] <= req.end_only ? 8'd0 : enc_b[i];
        end
      end
      if (push) begin
        otv_r   <= 1'b1;
        obyte_r <= byte_r[idx_r];
        obval_r <= bval_r;
        orun_r  <= run_end;
        oend_r  <= run_end && tend_r;
        if (run_end) begin
          pending_r <= 1'b0;
        end else begin
          idx_r <= idx_r + 2'd1;
        end
      end else if (out_tready) begin
        otv_r <= 1'b0;
      end
    end
  end

  assign busy       = pending_r;
  assign out_tvalid = otv_r;
  assign out_tdata  = obyte_r;
  assign out_tuser  = {orun_r, obval_r};
  assign out_tlast  = oend_r;

endmodule

@@ src/cid_text_unicode_remap_unit.sv @@
// a cid-forming byte passes the table read (S_LOOK), the emitter byte register and the output
//   register before out_tvalid rises; a byte that forms no cid and a table write leave in_tready
//   high; after a final byte that forms no cid, or a cid-forming byte, input is held off until
//   its end marker or n = 1..4 bytes are in the output register, longer while out_tready is low
// a clear request sweeps all 2**CID_BITS mark entries, one entry a cycle, no input taken
// reset (rst_n low, synchronous) clears the text state and starts the same sweep
`timescale 1ns / 1ps

module cid_text_unicode_remap_unit import cidrmp_pkg::*; #(
  parameter int CID_BITS  = DEF_CID_BITS,
  parameter int CODE_BITS = DEF_CODE_BITS
) (
  input  logic        clk,
  input  logic        rst_n,
  // input transaction
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [47:0] in_tdata,   // text_byte[7:0], entry_cid[23:8], entry_code[44:24], zero
  input  logic [1:0]  in_tuser,   // req_type[1:0]
  input  logic        in_tlast,   // text_last
  // result transaction
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [7:0]  out_tdata,  // out_byte[7:0]
  output logic [1:0]  out_tuser,  // byte_valid[0], run_last[1]
  output logic        out_tlast   // text_end
);

  typedef enum logic [1:0] {
    S_CLEAR,
    S_IDLE,
    S_LOOK
  } state_t;

  state_t state_r;

  // payload fields
  logic [7:0]           text_byte;
  logic [CID_W-1:0]     entry_cid;
  logic [CODE_W-1:0]    entry_code;

  logic                 in_acc;
  logic                 emit_busy;
  dec_res_t             dec;
  emit_req_t            ereq;

  // lookup context held across the memory read
  logic [CID_W-1:0]     cid_r;
  logic                 range_r;
  logic                 last_r;
  logic [CID_BITS-1:0]  clr_idx_r;

  // memory ports
  logic                 mem_we;
  logic [CID_BITS-1:0]  mem_waddr;
  logic [CODE_BITS:0]   mem_wdata;
  logic [CODE_BITS:0]   mem_rdata;

  logic                 is_text;
  logic                 is_write;
  logic                 is_clear;
  logic                 look_range;
  logic                 write_range;

  assign text_byte  = in_tdata[7:0];
  assign entry_cid  = in_tdata[23:8];
  assign entry_code = in_tdata[44:24];

  // only take a transaction when the emitter has drained its bytes into the output register
  assign in_tready = (state_r == S_IDLE) && !emit_busy;
  assign in_acc    = in_tvalid && in_tready;

  always_comb begin
    is_text  = 1'b0;
    is_write = 1'b0;
    is_clear = 1'b0;
    unique case (in_tuser)
      REQ_TEXT:  is_text  = 1'b1;
      REQ_WRITE: is_write = 1'b1;
      REQ_CLEAR: is_clear = 1'b1;
      default:   ;
    endcase
  end

  // cids beyond the table are never mapped, and writes to them are dropped
  assign look_range  = ((CID_W'(dec.cid) >> CID_BITS) == '0);
  assign write_range = ((CID_W'(entry_cid) >> CID_BITS) == '0);

  cidrmp_decode u_decode (
    .clk       (clk),
    .rst_n     (rst_n),
    .step      (in_acc && is_text),
    .text_byte (text_byte),
    .text_last (in_tlast),
    .res       (dec)
  );

  // table write port: sweep while clearing, otherwise entry writes
  always_comb begin
    if (state_r == S_CLEAR) begin
      mem_we    = 1'b1;
      mem_waddr = clr_idx_r;
      mem_wdata = '0;
    end else begin
      mem_we    = in_acc && is_write && write_range;
      mem_waddr = entry_cid[CID_BITS-1:0];
      mem_wdata = {1'b1, entry_code[CODE_BITS-1:0]};
    end
  end

  // read is launched at acceptance, data comes back in S_LOOK
  cidrmp_table #(
    .CID_BITS  (CID_BITS),
    .CODE_BITS (CODE_BITS)
  ) u_table (
    .clk   (clk),
    .we    (mem_we),
    .waddr (mem_waddr),
    .wdata (mem_wdata),
    .raddr (dec.cid[CID_BITS-1:0]),
    .rdata (mem_rdata)
  );

  // emitter request: the looked-up code (the cid itself when unmapped), or a bare end marker
  always_comb begin
    ereq.load     = 1'b0;
    ereq.end_only = 1'b0;
    ereq.last     = 1'b0;
    ereq.code     = '0;
    if (state_r == S_LOOK) begin
      ereq.load = 1'b1;
      ereq.last = last_r;
      if (range_r && mem_rdata[CODE_BITS]) begin
        ereq.code = CODE_W'(mem_rdata[CODE_BITS-1:0]);
      end else begin
        ereq.code = CODE_W'(cid_r);
      end
    end else if (in_acc && is_text && in_tlast && !dec.cid_vld) begin
      // end of text with nothing to emit still signals text_end
      ereq.load     = 1'b1;
      ereq.end_only = 1'b1;
      ereq.last     = 1'b1;
    end
  end

  cidrmp_emit u_emit (
    .clk        (clk),
    .rst_n      (rst_n),
    .req        (ereq),
    .busy       (emit_busy),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser),
    .out_tlast  (out_tlast)
  );

  // control fsm
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r   <= S_CLEAR;
      clr_idx_r <= '0;
    end else begin
      unique case (state_r)
        S_CLEAR: begin
          if (clr_idx_r == '1) begin
            state_r <= S_IDLE;
          end
          clr_idx_r <= clr_idx_r + CID_BITS'(1);
        end
        S_IDLE: begin
          if (in_acc) begin
            if (is_text && dec.cid_vld) begin
              state_r <= S_LOOK;
              cid_r   <= dec.cid;
              range_r <= look_range;
              last_r  <= in_tlast;
            end else if (is_clear) begin
              state_r   <= S_CLEAR;
              clr_idx_r <= '0;
            end
          end
        end
        S_LOOK: begin
          state_r <= S_IDLE;
        end
        default: begin
          state_r <= S_IDLE;
        end
      endcase
    end
  end

  // a new code is never handed over while the emitter still owns bytes
  assert property (@(posedge clk) disable iff (!rst_n)
    ereq.load |-> !emit_busy)
    else $error("emitter loaded while busy");

  // a cid-forming byte is followed by the S_LOOK state, with the emitter not busy
  assert property (@(posedge clk) disable iff (!rst_n)
    (in_acc && is_text && dec.cid_vld) |=> (state_r == S_LOOK) && emit_busy == 1'b0)
    else $error("lookup cycle missing after cid formed");

  // text end is only ever flagged on the last result of a run
  assert property (@(posedge clk) disable iff (!rst_n)
    (out_tvalid && out_tlast) |-> out_tuser[1])
    else $error("text end without run end");

  // no table write from the input side lands during the clearing sweep
  assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_CLEAR) |-> (!in_tready && mem_wdata[CODE_BITS] == 1'b0))
    else $error("input taken during clear sweep");

endmodule

@@ test/testbench.sv @@
`timescale 1ns / 1ps

module testbench;
  import cidrmp_pkg::*;

  // request kind that the block must swallow without any result
  localparam logic [1:0] REQ_UNUSED = 2'd3;

  localparam int RANDOM_TEXT_BYTES = 390;
  localparam int POOL_SIZE         = 16;
  localparam int HOLD_OFF_CYCLES   = 500;
  localparam int HOLD_OFF_AT       = 200;     // text bytes sent before the long hold-off
  localparam int DRAIN_CYCLES      = 20;
  // a clear sweeps 2**16 mark entries with nothing accepted, so allow a few times that
  localparam int IDLE_LIMIT        = 200000;

  // one emitted utf-8 byte as seen on the result channel
  typedef struct packed {
    logic [7:0] data;
    logic       byte_valid;
    logic       run_last;
    logic       text_end;
  } utf8_beat_t;

  // predicts the remapped utf-8 stream and checks the observed one against it
  class remap_scoreboard;
    bit [20:0]  code_mem [65536];
    bit         mark_mem [65536];
    bit [1:0]   seq_left;
    bit [15:0]  seq_point;
    bit [7:0]   held_byte;
    bit         held_valid;
    utf8_beat_t expected_beats [$];
    int         mismatches;
    int         beats_checked;

    function void report_mismatch(string msg);
      $display("[%0t] mismatch: %s", $time, msg);
      mismatches++;
    endfunction

    function bit [7:0] raw_of(bit [15:0] p);
      return (p < 16'h0100) ? p[7:0] : 8'h00;
    endfunction

    function int pending();
      return expected_beats.size();
    endfunction

    // called for every accepted input transaction
    function void note_input(bit [1:0] req, bit [7:0] b, bit last, bit [15:0] cid,
                             bit [20:0] code);
      bit         have_raw;
      bit [7:0]   raw;
      bit [15:0]  pair;
      bit [20:0]  u;
      bit [7:0]   enc [4];
      int         n;
      int         sh;
      utf8_beat_t beat;
      have_raw = 1'b0;
      raw      = 8'h00;
      n        = 0;
      if (req == REQ_WRITE) begin
        code_mem[cid] = code;
        mark_mem[cid] = 1'b1;
        return;
      end
      if (req == REQ_CLEAR) begin
        foreach (mark_mem[i]) mark_mem[i] = 1'b0;
        return;
      end
      if (req != REQ_TEXT) return;

      if (seq_left == 2'd1 || seq_left == 2'd2) begin
        sh = (int'(seq_left) - 1) * 6;
        seq_point = seq_point | (16'(b[5:0]) << sh);
        seq_left--;
        if (seq_left == 2'd0) begin
          raw = raw_of(seq_point);
          have_raw = 1'b1;
        end
      end else begin
        seq_left = 2'd0;
        if (!b[7]) begin
          raw = b;
          have_raw = 1'b1;
        end else if (b[7:5] == 3'b110) begin
          seq_point = {5'd0, b[4:0], 6'd0};
          seq_left  = 2'd1;
        end else if (b[7:4] == 4'b1110) begin
          seq_point = {b[3:0], 12'd0};
          seq_left  = 2'd2;
        end else begin
          raw = b;
          have_raw = 1'b1;
        end
      end

      // truncated sequence at end of text: missing bits are zero
      if (last && seq_left != 2'd0) begin
        raw = raw_of(seq_point);
        have_raw = 1'b1;
        seq_left = 2'd0;
      end

      if (have_raw) begin
        if (held_valid) begin
          pair = {held_byte, raw};
          u = mark_mem[pair] ? code_mem[pair] : 21'(pair);
          if (u < 21'h80) begin
            enc[0] = u[7:0];
            n = 1;
          end else if (u < 21'h800) begin
            enc[0] = {3'b110, u[10:6]};
            enc[1] = {2'b10, u[5:0]};
            n = 2;
          end else if (u < 21'h10000) begin
            enc[0] = {4'b1110, u[15:12]};
            enc[1] = {2'b10, u[11:6]};
            enc[2] = {2'b10, u[5:0]};
            n = 3;
          end else begin
            enc[0] = {5'b11110, u[20:18]};
            enc[1] = {2'b10, u[17:12]};
            enc[2] = {2'b10, u[11:6]};
            enc[3] = {2'b10, u[5:0]};
            n = 4;
          end
          held_valid = 1'b0;
        end else begin
          held_byte  = raw;
          held_valid = 1'b1;
        end
      end

      if (last) begin
        // odd trailing byte is dropped with the rest of the text state
        seq_left   = 2'd0;
        seq_point  = 16'h0000;
        held_byte  = 8'h00;
        held_valid = 1'b0;
        if (n == 0) begin
          beat = '{data: 8'h00, byte_valid: 1'b0, run_last: 1'b1, text_end: 1'b1};
          expected_beats = {expected_beats, beat};
          return;
        end
      end

      for (int k = 0; k < n; k++) begin
        beat.data       = enc[k];
        beat.byte_valid = 1'b1;
        beat.run_last   = (k == n - 1);
        beat.text_end   = (k == n - 1) && last;
        expected_beats = {expected_beats, beat};
      end
    endfunction

    // called for every accepted result transaction
    function void check_result(utf8_beat_t got);
      utf8_beat_t want;
      beats_checked++;
      if (expected_beats.size() == 0) begin
        report_mismatch($sformatf("unexpected result, byte %02h", got.data));
        return;
      end
      want = expected_beats.pop_front();
      if (got.data != want.data)
        report_mismatch($sformatf("out_byte %02h, expected %02h", got.data, want.data));
      if (got.byte_valid != want.byte_valid)
        report_mismatch($sformatf("byte_valid %0b, expected %0b", got.byte_valid,
                                  want.byte_valid));
      if (got.run_last != want.run_last)
        report_mismatch($sformatf("run_last %0b, expected %0b", got.run_last, want.run_last));
      if (got.text_end != want.text_end)
        report_mismatch($sformatf("text_end %0b, expected %0b", got.text_end, want.text_end));
    endfunction
  endclass

  logic        clk        = 1'b0;
  logic        rst_n      = 1'b0;
  logic        in_tvalid  = 1'b0;
  logic        in_tready;
  logic [47:0] in_tdata   = '0;    // text_byte[7:0], entry_cid[23:8], entry_code[44:24], zero
  logic [1:0]  in_tuser   = '0;    // req_type[1:0]
  logic        in_tlast   = 1'b0;  // text_last
  logic        out_tvalid;
  logic        out_tready = 1'b0;
  logic [7:0]  out_tdata;          // out_byte[7:0]
  logic [1:0]  out_tuser;          // byte_valid[0], run_last[1]
  logic        out_tlast;          // text_end

  remap_scoreboard sb = new();

  // run statistics for the closing summary
  int text_bytes  = 0;
  int texts_sent  = 0;
  int writes_sent = 0;
  int clears_sent = 0;

  cid_text_unicode_remap_unit dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .in_tlast   (in_tlast),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser),
    .out_tlast  (out_tlast)
  );

  // 10 ns clock
  initial begin
    forever #5 clk = ~clk;
  end

  // mostly back-to-back, sometimes a short gap, rarely a long pause
  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (r < 60) return 0;
    if (r < 92) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  // offer one input transaction after a random gap and wait for the handshake
  task automatic send_item(input logic [1:0] req, input logic [7:0] b, input logic last,
                           input logic [15:0] cid, input logic [20:0] code);
    int gap;
    gap = pick_gap();
    if (gap > 0) begin
      in_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tuser  <= req;
    in_tlast  <= last;
    in_tdata  <= {3'b000, code, cid, b};
    do @(posedge clk); while (!in_tready);
    sb.note_input(req, b, last, cid, code);
    if (req == REQ_TEXT) begin
      text_bytes++;
      if (last) texts_sent++;
    end
    if (req == REQ_WRITE) writes_sent++;
    if (req == REQ_CLEAR) clears_sent++;
  endtask

  // text byte with random junk in the unused fields
  task automatic send_text(input logic [7:0] b, input logic last);
    send_item(REQ_TEXT, b, last, 16'($urandom), 21'($urandom));
  endtask

  // table write with random junk in the text fields
  task automatic send_write(input logic [15:0] cid, input logic [20:0] code);
    send_item(REQ_WRITE, 8'($urandom), 1'($urandom), cid, code);
  endtask

  // code point spread evenly over the four utf-8 lengths
  function automatic logic [20:0] rand_code();
    case ($urandom_range(0, 3))
      0:       return 21'($urandom_range(0, 'h7F));
      1:       return 21'($urandom_range('h80, 'h7FF));
      2:       return 21'($urandom_range('h800, 'hFFFF));
      default: return 21'($urandom_range('h10000, 'h1FFFFF));
    endcase
  endfunction

  // send one raw byte in some loose utf-8 form that decodes back to it
  task automatic put_raw(input logic [7:0] r, input logic fin);
    logic [7:0] seq [3];
    int         len;
    int         pick;
    logic       direct_ok;
    pick = $urandom_range(0, 99);
    direct_ok = (r < 8'hC0) || (r >= 8'hF0);
    if (r == 8'h00 && pick < 12) begin
      // two-byte point of 0x100 or more collapses to zero
      seq[0] = {3'b110, 5'($urandom_range(4, 31))};
      seq[1] = 8'($urandom);
      len = 2;
    end else if (r == 8'h00 && pick < 25) begin
      // three-byte point collapses to zero as well
      seq[0] = {4'b1110, 4'($urandom_range(1, 15))};
      seq[1] = 8'($urandom);
      seq[2] = 8'($urandom);
      len = 3;
    end else if (direct_ok && pick < 70) begin
      seq[0] = r;
      len = 1;
    end else begin
      // possibly overlong two-byte form, continuation top bits unchecked
      seq[0] = {6'b110000, r[7:6]};
      seq[1] = {2'($urandom), r[5:0]};
      len = 2;
    end
    for (int i = 0; i < len; i++) send_text(seq[i], fin && (i == len - 1));
  endtask

  // result channel monitor
  always @(posedge clk) begin
    if (rst_n && out_tvalid && out_tready)
      sb.check_result('{data: out_tdata, byte_valid: out_tuser[0], run_last: out_tuser[1],
                        text_end: out_tlast});
  end

  // receiver: random ready pattern plus one long hold-off while the sender keeps going
  initial begin : result_sink
    int run_len;
    int gap;
    bit held_off;
    held_off = 1'b0;
    wait (rst_n);
    @(posedge clk);
    forever begin
      if (!held_off && text_bytes >= HOLD_OFF_AT) begin
        held_off = 1'b1;
        out_tready <= 1'b0;
        repeat (HOLD_OFF_CYCLES) @(posedge clk);
      end
      run_len = $urandom_range(1, 24);
      out_tready <= 1'b1;
      repeat (run_len) @(posedge clk);
      gap = pick_gap();
      if (gap > 0) begin
        out_tready <= 1'b0;
        repeat (gap) @(posedge clk);
      end
    end
  end

  // watchdog: too long without any transaction on either side
  initial begin : watchdog
    int idle;
    idle = 0;
    while (idle < IDLE_LIMIT) begin
      @(posedge clk);
      if ((in_tvalid && in_tready) || (out_tvalid && out_tready)) idle = 0;
      else idle++;
    end
    $display("FAILED: results differ");
    $finish;
  end

  initial begin : stimulus
    logic [15:0] cid_pool [POOL_SIZE];
    logic [15:0] c;
    int          ncid;
    int          tail;
    int          start_bytes;
    int          next_clear_at;

    // reset, then the block sweeps its mark memory before taking input
    repeat (8) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // directed: table extremes and each code length
    send_write(16'h0000, 21'h1FFFFF);
    send_write(16'hFFFF, 21'h000000);
    send_write(16'h4142, 21'h0007FF);
    send_write(16'h7FF0, 21'h010000);
    send_text(8'h00, 1'b0);                // cid 0000 -> widest four-byte code
    send_text(8'h00, 1'b0);
    send_text(8'hFF, 1'b0);                // cid ffff -> code 0, ends the text
    send_text(8'hFF, 1'b1);
    send_text(8'hC3, 1'b0);                // two-byte sequence giving raw ff
    send_text(8'hBF, 1'b0);
    send_text(8'h80, 1'b0);                // raw pass-through, unmapped cid ff80
    send_text(8'hE4, 1'b0);                // three-byte point above ff -> raw 0
    send_text(8'hB8, 1'b0);
    send_text(8'h80, 1'b0);
    send_text(8'h01, 1'b0);
    send_text(8'h41, 1'b0);                // mapped to a two-byte code
    send_text(8'h42, 1'b0);
    send_text(8'h7F, 1'b0);                // unused request in the middle of a pair
    send_item(REQ_UNUSED, 8'hFF, 1'b1, 16'hFFFF, 21'h1FFFFF);
    send_text(8'hF0, 1'b1);
    send_text(8'h41, 1'b0);                // clear in the middle of a pair
    send_item(REQ_CLEAR, 8'h00, 1'b0, 16'h0000, 21'h000000);
    send_text(8'h42, 1'b0);                // now unmapped
    send_text(8'h43, 1'b0);
    send_text(8'hE1, 1'b1);                // truncated lead completes the pair
    send_text(8'hC2, 1'b1);                // truncated, odd byte dropped: bare end marker

    // random: mostly well-formed texts over a pool of mapped cids
    foreach (cid_pool[i]) begin
      cid_pool[i] = 16'($urandom);
      send_write(cid_pool[i], rand_code());
    end
    start_bytes   = text_bytes;
    next_clear_at = 150;
    while (text_bytes - start_bytes < RANDOM_TEXT_BYTES) begin
      if (text_bytes - start_bytes >= next_clear_at) begin
        send_item(REQ_CLEAR, 8'($urandom), 1'($urandom), 16'($urandom), 21'($urandom));
        next_clear_at += 200;
        for (int i = 0; i < POOL_SIZE; i += 2) send_write(cid_pool[i], rand_code());
      end
      if ($urandom_range(0, 99) < 12) begin
        // noise text of arbitrary bytes
        ncid = $urandom_range(1, 8);
        for (int j = 0; j < ncid; j++) send_text(8'($urandom), j == ncid - 1);
      end else begin
        ncid = $urandom_range(1, 6);
        tail = $urandom_range(0, 9);
        for (int j = 0; j < ncid; j++) begin
          if ($urandom_range(0, 9) == 0)
            send_write(cid_pool[$urandom_range(0, POOL_SIZE - 1)], rand_code());
          if ($urandom_range(0, 49) == 0)
            send_item(REQ_UNUSED, 8'($urandom), 1'($urandom), 16'($urandom), 21'($urandom));
          c = ($urandom_range(0, 9) < 6) ? cid_pool[$urandom_range(0, POOL_SIZE - 1)]
                                         : 16'($urandom);
          put_raw(c[15:8], 1'b0);
          put_raw(c[7:0], (j == ncid - 1) && (tail < 7));
        end
        case (tail)
          7: put_raw(8'($urandom), 1'b1);                        // odd trailing byte
          8: send_text({3'b110, 5'($urandom)}, 1'b1);            // cut two-byte sequence
          9: begin                                               // cut three-byte sequence
            if ($urandom_range(0, 1) == 1) begin
              send_text({4'b1110, 4'($urandom)}, 1'b0);
              send_text(8'($urandom), 1'b1);
            end else begin
              send_text({4'b1110, 4'($urandom)}, 1'b1);
            end
          end
          default: ;
        endcase
      end
    end
    in_tvalid <= 1'b0;

    // drain, then keep the monitor running to catch stray results
    while (sb.pending() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);

    $display("covered %0d text bytes in %0d texts, %0d table writes, %0d clears",
             text_bytes, texts_sent, writes_sent, clears_sent);
    $display("checked %0d result transactions across a %0d-cycle receiver hold-off",
             sb.beats_checked, HOLD_OFF_CYCLES);
    if (sb.mismatches == 0) begin
      $display("PASSED: all results match");
    end else begin
      $display("FAILED: results differ");
    end
    $finish;
  end

endmodule

@@ files.f @@
src/cidrmp_pkg.sv
src/cidrmp_table.sv
src/cidrmp_decode.sv
src/cidrmp_emit.sv
src/cid_text_unicode_remap_unit.sv
test/testbench.sv
